FILE: src/hcbp_pkg.sv
// shared types and constants of the huffman code bit packer
// no dependencies; imported by every module of the block but hcbp_ram
package hcbp_pkg;

  localparam int unsigned CODE_WORD_BITS = 32;
  localparam int unsigned LEN_BITS       = 6;
  localparam int unsigned PEND_BITS      = 7;
  localparam int unsigned ACC_BITS       = PEND_BITS + CODE_WORD_BITS;
  localparam int unsigned BUF_BITS       = 32;
  localparam int unsigned BUF_CNT_BITS   = 3;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  symbol;
    logic [31:0] code_word;
    logic [5:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic [2:0] pad_bits;
    logic       is_flush;
    logic       last;
  } out_item_t;

  // bit accumulator, newest bit in bit 0
  typedef struct packed {
    logic [PEND_BITS-1:0] bits;
    logic [2:0]           count;
  } pend_t;

  // result bytes of one item handed to the output buffer, earliest byte on top
  typedef struct packed {
    logic [BUF_BITS-1:0]     bytes;
    logic [BUF_CNT_BITS-1:0] count;
    logic                    present;
    logic [2:0]              pad;
    logic                    flush;
  } buf_load_t;

endpackage

FILE: src/hcbp_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module hcbp_ram #(
  parameter int unsigned WIDTH = 38,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/hcbp_pack.sv
// appends one code word to the accumulator, cuts out full bytes, pads on flush
// depends on hcbp_pkg
module hcbp_pack
  import hcbp_pkg::*;
(
  input  logic                      enc,
  input  logic                      flush,
  input  pend_t                     pend,
  input  logic [CODE_WORD_BITS-1:0] code,
  input  logic [LEN_BITS-1:0]       len,
  output buf_load_t                 res,
  output pend_t                     pend_nxt
);

  logic [ACC_BITS-1:0] acc;
  logic [ACC_BITS-1:0] aligned;
  logic [LEN_BITS-1:0] total;
  logic [2:0]          rem;
  logic [7:0]          flush_byte;

  always_comb begin
    acc     = (ACC_BITS'(pend.bits) << len) | ACC_BITS'(code);
    total   = LEN_BITS'(pend.count) + len;
    // earliest pending bit moved to the top of the word
    aligned = acc << (LEN_BITS'(ACC_BITS) - total);
    rem     = total[2:0];
    flush_byte = 8'({1'b0, pend.bits} << (4'd8 - {1'b0, pend.count}));
  end

  always_comb begin
    res      = '0;
    pend_nxt = pend;
    priority if (enc) begin
      res.bytes      = aligned[ACC_BITS-1 -: BUF_BITS];
      res.count      = total[LEN_BITS-1:3];
      res.present    = 1'b1;
      pend_nxt.count = rem;
      pend_nxt.bits  = acc[PEND_BITS-1:0] & (7'h7f >> (3'd7 - rem));
    end else if (flush) begin
      res.bytes   = {flush_byte, {(BUF_BITS-8){1'b0}}};
      res.count   = BUF_CNT_BITS'(1);
      res.present = (pend.count != 3'd0);
      res.pad     = 3'd0 - pend.count;
      res.flush   = 1'b1;
      pend_nxt    = '0;
    end else begin
      // load, unused command or no item: nothing to hand over
      res      = '0;
      pend_nxt = pend;
    end
  end

endmodule

FILE: src/hcbp_outbuf.sv
// output buffer holding the result bytes of one item, one transfer per byte
// depends on hcbp_pkg
module hcbp_outbuf
  import hcbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  buf_load_t res,
  output logic      free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [BUF_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [BUF_BITS-1:0]     bytes_r, bytes_nxt;
  logic                    present_r;
  logic [2:0]              pad_r;
  logic                    flush_r;
  logic                    xfer;

  assign out_valid = (cnt_r != '0);
  assign xfer      = out_valid && !out_stall;
  // empty, or handing over its final byte in this cycle
  assign free      = (cnt_r == '0) || ((cnt_r == BUF_CNT_BITS'(1)) && !out_stall);

  always_comb begin
    cnt_nxt   = cnt_r;
    bytes_nxt = bytes_r;
    priority if (load) begin
      cnt_nxt   = res.count;
      bytes_nxt = res.bytes;
    end else if (xfer) begin
      cnt_nxt   = cnt_r - BUF_CNT_BITS'(1);
      bytes_nxt = bytes_r << 8;
    end else begin
      cnt_nxt   = cnt_r;
      bytes_nxt = bytes_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    if (load) begin
      present_r <= res.present;
      pad_r     <= res.pad;
      flush_r   <= res.flush;
    end
  end

  assign out_data.out_byte     = bytes_r[BUF_BITS-1 -: 8];
  assign out_data.byte_present = present_r;
  assign out_data.pad_bits     = pad_r;
  assign out_data.is_flush     = flush_r;
  assign out_data.last         = (cnt_r == BUF_CNT_BITS'(1));

endmodule

FILE: src/huffman_code_bit_packer.sv
// huffman code bit packer top level: code store, accumulator and output buffer
// depends on hcbp_pkg, hcbp_ram, hcbp_pack and hcbp_outbuf
//
// usage
//   input channel (in_valid, in_stall, in_data): one command per transfer.
//     load writes a symbol's code word and length, encode appends the
//     symbol's code to the bit accumulator, flush pads to a byte boundary.
//   result channel (out_valid, out_stall, out_data): one byte per transfer,
//     earliest bit in bit 7; last marks the final result of an item.
//   path: the first result of an item is offered once the item has passed the
//     input register (code store read) and been packed into the output buffer,
//     which takes it only when the buffer is free.
//   throughput: one item per cycle while each item gives at most one result
//     and out_stall is low; an encode completing n bytes hands them over
//     one per transfer, so the output port sets the rate, one byte per cycle.
//   reset: the accumulator is emptied and every symbol marked not loaded;
//     the code store itself is not cleared, no clearing pass is needed.
//   stall: a stalled result holds its byte; the input register takes one
//     more item behind it, then in_stall rises until the buffer drains.
//   encodes of unloaded or out of range symbols, out of range loads and the
//     unused command give no result.
module huffman_code_bit_packer
  import hcbp_pkg::*;
#(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // stored code width, and the length field wide enough for it
  localparam int unsigned CODE_W = (MAX_CODE_LEN < CODE_WORD_BITS) ?
                                   MAX_CODE_LEN : CODE_WORD_BITS;
  localparam int unsigned LEN_W  = $clog2(CODE_W + 1);
  localparam int unsigned ADDR_W = $clog2(SYMBOL_COUNT);
  localparam int unsigned ENT_W  = CODE_W + LEN_W;

  logic                    in_xfer;
  logic                    sym_in_range;
  logic [ADDR_W-1:0]       sym_idx;
  logic                    len_ok;
  logic [CODE_W-1:0]       code_mask;
  logic                    ram_we;
  logic                    ram_re;
  logic [ENT_W-1:0]        ram_wdata;
  logic [ENT_W-1:0]        ram_rdata;
  logic                    enc_hit;

  logic [SYMBOL_COUNT-1:0] loaded_r;

  // input register: decoded command, store read data comes with it
  logic                    s1_valid_r;
  logic                    s1_enc_r;
  logic                    s1_flush_r;
  logic                    s1_adv;

  pend_t                   pend_r, pend_nxt;
  buf_load_t               pack_res;
  logic                    ob_free;

  assign in_xfer      = in_valid && !in_stall;
  assign sym_in_range = ({1'b0, in_data.symbol} < 9'(SYMBOL_COUNT));
  assign sym_idx      = in_data.symbol[ADDR_W-1:0];
  assign len_ok       = ({1'b0, in_data.code_length} <= 7'(CODE_W));

  // keep only the low code_length bits of a loaded code word
  always_comb begin
    for (int i = 0; i < CODE_W; i++) begin
      code_mask[i] = (7'(i) < {1'b0, in_data.code_length});
    end
  end

  assign ram_we    = in_xfer && (in_data.command == CMD_LOAD) && sym_in_range && len_ok;
  assign ram_wdata = {in_data.code_length[LEN_W-1:0],
                      in_data.code_word[CODE_W-1:0] & code_mask};
  assign enc_hit   = (in_data.command == CMD_ENCODE) && sym_in_range && loaded_r[sym_idx];
  // read only on an encode transfer so the data holds while the item waits
  assign ram_re    = in_xfer && enc_hit;

  hcbp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sym_idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (sym_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
    end else if (ram_we) begin
      loaded_r[sym_idx] <= 1'b1;
    end
  end

  // the input register moves on once the output buffer can take its bytes
  assign s1_adv   = s1_valid_r && ob_free;
  assign in_stall = s1_valid_r && !ob_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_enc_r   <= 1'b0;
      s1_flush_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
      s1_enc_r   <= enc_hit;
      s1_flush_r <= (in_data.command == CMD_FLUSH);
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
      s1_enc_r   <= 1'b0;
      s1_flush_r <= 1'b0;
    end
  end

  hcbp_pack u_pack (
    .enc      (s1_enc_r),
    .flush    (s1_flush_r),
    .pend     (pend_r),
    .code     (CODE_WORD_BITS'(ram_rdata[CODE_W-1:0])),
    .len      (LEN_BITS'(ram_rdata[ENT_W-1:CODE_W])),
    .res      (pack_res),
    .pend_nxt (pend_nxt)
  );

  // accumulator commits when the item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (s1_adv) begin
      pend_r <= pend_nxt;
    end
  end

  hcbp_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_adv),
    .res       (pack_res),
    .free      (ob_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // bits above the pending count stay clear
  a_pend_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r.bits >> pend_r.count) == '0)
    else $error("accumulator holds stray bits");

  // the bytes of one item follow without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |=> out_valid)
    else $error("result sequence broken before last");

  // only a flush result may lack a byte or carry padding
  a_enc_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.is_flush) |-> (out_data.byte_present && out_data.pad_bits == 3'd0))
    else $error("encode result with flush fields");

  // a flush result is always the single and final result of its item
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_flush) |-> out_data.last)
    else $error("flush result not marked last");
`endif

endmodule
